/* src/acs_pkg.sv */
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the attention coherence score block.
// ----------------------------------------------------------------------------
package acs_pkg;

    // field and accumulator widths
    localparam int WEIGHT_W   = 17;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 18;
    localparam int ROWSUM_W   = 34;
    localparam int XLOG_W     = 56;
    localparam int TOTAL_W    = 48;
    localparam int ENTSUM_W   = 40;
    localparam int LG_IN_W    = 40;
    localparam int LG_W       = 22;
    localparam int PROD_W     = 39;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 48;
    localparam int ACC_W      = 34;
    localparam int MASS_W     = 17;
    localparam int ENT_W      = 21;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // fixed-point constants
    localparam logic [MASS_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [ENT_W-1:0]  ENT_LIMIT   = 21'd1048576;
    localparam logic [ENT_W-1:0]  CONS_LIMIT  = 21'd131072;
    localparam logic [ACC_W-1:0]  MASS_COEF   = 34'd26214;
    localparam logic [ACC_W-1:0]  FOCUS_COEF  = 34'd19661;
    localparam logic [ACC_W-1:0]  CONS_TERM   = 34'd1288503296;
    localparam logic [ACC_W-1:0]  ROUND_HALF  = 34'd32768;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REGION   = 2'd1;
    localparam logic [1:0] STATUS_NO_QUERY = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT,
        REG_COLUMN_COUNT,
        REG_WINDOW_START,
        REG_WINDOW_LENGTH,
        REG_QUERY_FIRST,
        REG_QUERY_COUNT
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] row_count;
        logic [CFG_W-1:0] column_count;
        logic [CFG_W-1:0] window_start;
        logic [CFG_W-1:0] window_length;
        logic [CFG_W-1:0] query_first;
        logic [CFG_W-1:0] query_count;
    } cfg_t;

    // one classified weight
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                in_query;
        logic                in_window;
        logic                row_end;
        logic                mat_end;
    } beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [MASS_W-1:0] mass;
        logic [ENT_W-1:0]  entropy;
        logic              consistent;
        logic [MASS_W-1:0] score;
        logic [CFG_W-1:0]  token_total;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOG_W,
        BK_ACC,
        BK_ROW,
        BK_ROW_W,
        BK_ROW_CLR,
        BK_MASS,
        BK_MASS_W,
        BK_ENT_W,
        BK_MAXE_W,
        BK_FOC_W,
        BK_SC1,
        BK_SC2,
        BK_SC3,
        BK_EMIT
    } back_state_t;

    // zero becomes one, too large becomes the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (DIM_W'(v) > lim)
            begin
                r = lim;
            end
            else
            begin
                r = DIM_W'(v);
            end
            return r;
        end
    endfunction

endpackage

/* src/acs_front.sv */
// ----------------------------------------------------------------------------
// acs_front
// Tracks row and column of each accepted weight and tags it for the back end.
// ----------------------------------------------------------------------------
module acs_front
    import acs_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                accept,
    input  logic [WEIGHT_W-1:0] weight,
    output beat_t               beat
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CW-1:0]    col_pos_reg;
    logic [CW-1:0]    col_pos_next;
    logic [RW-1:0]    row_pos_reg;
    logic [RW-1:0]    row_pos_next;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic             col_last;
    logic             row_last;

    assign cols    = clamp_dim(cfg.column_count, DIM_W'(MAX_COLUMNS));
    assign rows    = clamp_dim(cfg.row_count, DIM_W'(MAX_ROWS));
    assign col_ext = DIM_W'(col_pos_reg);
    assign row_ext = DIM_W'(row_pos_reg);

    assign col_last = (col_ext + DIM_W'(1)) >= cols;
    assign row_last = (row_ext + DIM_W'(1)) >= rows;

    // classification of the current beat
    always_comb
    begin
        beat.weight    = weight;
        beat.in_query  = (row_ext >= DIM_W'(cfg.query_first)) &&
                         (row_ext < DIM_W'(cfg.query_first) + DIM_W'(cfg.query_count));
        beat.in_window = (col_ext >= DIM_W'(cfg.window_start)) &&
                         (col_ext < DIM_W'(cfg.window_start) + DIM_W'(cfg.window_length));
        beat.row_end   = col_last;
        beat.mat_end   = col_last && row_last;
    end

    // position counters
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_pos_next = '0;
                row_pos_next = row_last ? '0 : row_pos_reg + RW'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

/* src/acs_fifo.sv */
// ----------------------------------------------------------------------------
// acs_fifo
// Short queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module acs_fifo
    import acs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t din,
    output logic  full,
    input  logic  pop,
    output beat_t dout,
    output logic  empty
);

    beat_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (FIFO_PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (FIFO_PTR_W+1)'(1);
            end
        end
    end

endmodule

/* src/acs_log.sv */
// ----------------------------------------------------------------------------
// acs_log
// Iterative log2 in Q.16: normalise, then sixteen squaring steps.
// ----------------------------------------------------------------------------
module acs_log
    import acs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LG_IN_W-1:0] x,
    output logic               done,
    output logic [LG_W-1:0]    result
);

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         step_reg;
    logic [30:0]        m_reg;
    logic [5:0]         k_reg;
    logic [15:0]        frac_reg;
    logic               zero_reg;
    logic [LG_IN_W-1:0] v;
    logic [5:0]         sh;
    logic [61:0]        sq;
    logic [31:0]        t;

    // leading-one normalisation, top bit moved to the msb
    always_comb
    begin
        v  = x;
        sh = '0;
        if (v[39:8] == '0)
        begin
            v  = v << 32;
            sh = sh + 6'd32;
        end
        if (v[39:24] == '0)
        begin
            v  = v << 16;
            sh = sh + 6'd16;
        end
        if (v[39:32] == '0)
        begin
            v  = v << 8;
            sh = sh + 6'd8;
        end
        if (v[39:36] == '0)
        begin
            v  = v << 4;
            sh = sh + 6'd4;
        end
        if (v[39:38] == '0)
        begin
            v  = v << 2;
            sh = sh + 6'd2;
        end
        if (!v[39])
        begin
            v  = v << 1;
            sh = sh + 6'd1;
        end
    end

    // one squaring of the Q1.30 mantissa
    assign sq = 62'(m_reg) * 62'(m_reg);
    assign t  = sq[61:30];

    assign done   = done_reg;
    assign result = zero_reg ? '0 : {k_reg, frac_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg    <= v[39:9];
            k_reg    <= 6'd39 - sh;
            frac_reg <= '0;
            zero_reg <= (x == '0);
        end
        else if (busy_reg)
        begin
            m_reg    <= t[31] ? t[31:1] : t[30:0];
            frac_reg <= {frac_reg[14:0], t[31]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/acs_div.sv */
// ----------------------------------------------------------------------------
// acs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acs_div
    import acs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           count_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // trial subtract
    assign rem_sh = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign fits   = rem_sh >= {1'b0, den_reg};

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == 6'd63);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 6'd1;
                if (count_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/acs_back.sv */
// ----------------------------------------------------------------------------
// acs_back
// Sequencer that accumulates weights, row entropies and the final score.
// ----------------------------------------------------------------------------
module acs_back
    import acs_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    fifo_empty,
    input  beat_t   fifo_head,
    output logic    fifo_pop,
    output logic    res_valid,
    input  logic    res_pop,
    output result_t res
);

    back_state_t          state_reg;
    back_state_t          state_next;
    beat_t                beat_reg;
    logic [ROWSUM_W-1:0]  row_sum_reg;
    logic [XLOG_W-1:0]    row_x_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   window_reg;
    logic [ENTSUM_W-1:0]  ent_sum_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [1:0]           status_reg;
    logic [MASS_W-1:0]    mass_reg;
    logic [ENT_W-1:0]     ent_reg;
    logic                 cons_reg;
    logic [MASS_W-1:0]    focus_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    result_t              res_reg;

    logic                 lg_start;
    logic [LG_IN_W-1:0]   lg_x;
    logic                 lg_done;
    logic [LG_W-1:0]      lg_result;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic [DIM_W-1:0]     cols;
    logic [1:0]           status_calc;
    logic                 region_bad;
    logic                 need_log;
    logic                 need_row;
    logic                 need_focus;
    logic [LG_W-1:0]      focus_diff;
    logic [ACC_W-1:0]     score_raw;
    logic                 emit_go;
    result_t              emit_res;

    acs_log u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lg_start),
        .x      (lg_x),
        .done   (lg_done),
        .result (lg_result)
    );

    acs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cols = clamp_dim(cfg.column_count, DIM_W'(MAX_COLUMNS));

    // region check for the end of a matrix
    always_comb
    begin
        region_bad = (cfg.row_count == '0) ||
                     (DIM_W'(cfg.row_count) > DIM_W'(MAX_ROWS)) ||
                     (cfg.column_count == '0) ||
                     (DIM_W'(cfg.column_count) > DIM_W'(MAX_COLUMNS)) ||
                     ((DIM_W'(cfg.window_start) + DIM_W'(cfg.window_length)) >
                      DIM_W'(cfg.column_count)) ||
                     ((DIM_W'(cfg.query_first) + DIM_W'(cfg.query_count)) >
                      DIM_W'(cfg.row_count));
        if (region_bad)
        begin
            status_calc = STATUS_REGION;
        end
        else if (cfg.query_count == '0)
        begin
            status_calc = STATUS_NO_QUERY;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    assign need_log   = fifo_head.in_query && (fifo_head.weight != '0);
    assign need_row   = beat_reg.in_query && (row_sum_reg != '0);
    assign need_focus = (lg_result != '0) && (LG_W'(ent_reg) < lg_result);
    assign focus_diff = lg_result - LG_W'(ent_reg);
    assign score_raw  = acc_reg >> 16;
    assign emit_go    = (state_reg == BK_EMIT) && (!res_valid_reg || res_pop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = need_log ? BK_LOG_W : BK_ROW;
                end
            end
            BK_LOG_W:
            begin
                if (lg_done)
                begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC:     state_next = BK_ROW;
            BK_ROW:
            begin
                if (!beat_reg.row_end)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = need_row ? BK_ROW_W : BK_ROW_CLR;
                end
            end
            BK_ROW_W:
            begin
                if (div_done)
                begin
                    state_next = BK_ROW_CLR;
                end
            end
            BK_ROW_CLR: state_next = beat_reg.mat_end ? BK_MASS : BK_IDLE;
            BK_MASS:    state_next = (status_calc == STATUS_OK) ? BK_MASS_W : BK_EMIT;
            BK_MASS_W:
            begin
                if (div_done)
                begin
                    state_next = BK_ENT_W;
                end
            end
            BK_ENT_W:
            begin
                if (div_done)
                begin
                    state_next = BK_MAXE_W;
                end
            end
            BK_MAXE_W:
            begin
                if (lg_done)
                begin
                    state_next = need_focus ? BK_FOC_W : BK_SC1;
                end
            end
            BK_FOC_W:
            begin
                if (div_done)
                begin
                    state_next = BK_SC1;
                end
            end
            BK_SC1:     state_next = BK_SC2;
            BK_SC2:     state_next = BK_SC3;
            BK_SC3:     state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb
    begin
        fifo_pop  = 1'b0;
        lg_start  = 1'b0;
        lg_x      = LG_IN_W'(fifo_head.weight);
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(row_x_reg);
        div_den   = DIV_DEN_W'(row_sum_reg);
        case (state_reg)
            BK_IDLE:
            begin
                fifo_pop = !fifo_empty;
                lg_start = !fifo_empty && need_log;
            end
            BK_ROW:
            begin
                lg_x      = LG_IN_W'(row_sum_reg);
                lg_start  = beat_reg.row_end && need_row;
                div_start = beat_reg.row_end && need_row;
            end
            BK_MASS:
            begin
                div_num   = {window_reg, 16'd0};
                div_den   = total_reg;
                div_start = (status_calc == STATUS_OK);
            end
            BK_MASS_W:
            begin
                div_num   = DIV_NUM_W'(ent_sum_reg);
                div_den   = DIV_DEN_W'(cfg.query_count);
                div_start = div_done;
            end
            BK_ENT_W:
            begin
                lg_x     = LG_IN_W'(cols);
                lg_start = div_done;
            end
            BK_MAXE_W:
            begin
                div_num   = DIV_NUM_W'({focus_diff, 16'd0});
                div_den   = DIV_DEN_W'(lg_result);
                div_start = lg_done && need_focus;
            end
            default:
            begin
                fifo_pop = 1'b0;
            end
        endcase
    end

    // result beat as it leaves the sequencer
    always_comb
    begin
        emit_res        = '0;
        emit_res.status = status_reg;
        if (status_reg == STATUS_OK)
        begin
            emit_res.mass        = mass_reg;
            emit_res.entropy     = ent_reg;
            emit_res.consistent  = cons_reg;
            emit_res.score       = (score_raw > ACC_W'(ONE_Q16)) ? ONE_Q16
                                   : score_raw[MASS_W-1:0];
            emit_res.token_total = cfg.window_length;
        end
    end

    // result slot occupancy
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_pop)
        begin
            res_valid_next = 1'b0;
        end
        if (emit_go)
        begin
            res_valid_next = 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                beat_reg <= fifo_head;
            end
            BK_LOG_W:
            begin
                if (lg_done)
                begin
                    prod_reg <= PROD_W'(beat_reg.weight) * PROD_W'(lg_result);
                end
            end
            BK_MASS:
            begin
                status_reg <= status_calc;
                focus_reg  <= '0;
            end
            BK_MASS_W:
            begin
                if (div_done)
                begin
                    if (total_reg == '0)
                    begin
                        mass_reg <= '0;
                    end
                    else
                    begin
                        mass_reg <= (div_quo > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16
                                                                   : div_quo[MASS_W-1:0];
                    end
                end
            end
            BK_ENT_W:
            begin
                if (div_done)
                begin
                    ent_reg  <= (div_quo > DIV_NUM_W'(ENT_LIMIT)) ? ENT_LIMIT
                                                                 : div_quo[ENT_W-1:0];
                    cons_reg <= (div_quo < DIV_NUM_W'(CONS_LIMIT));
                end
            end
            BK_FOC_W:
            begin
                if (div_done)
                begin
                    focus_reg <= div_quo[MASS_W-1:0];
                end
            end
            BK_SC1:
            begin
                acc_reg <= MASS_COEF * ACC_W'(mass_reg);
            end
            BK_SC2:
            begin
                acc_reg <= acc_reg + FOCUS_COEF * ACC_W'(focus_reg);
            end
            BK_SC3:
            begin
                acc_reg <= acc_reg + (cons_reg ? CONS_TERM : '0) + ROUND_HALF;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // accumulators, result slot and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            row_sum_reg   <= '0;
            row_x_reg     <= '0;
            total_reg     <= '0;
            window_reg    <= '0;
            ent_sum_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            case (state_reg)
                BK_IDLE:
                begin
                    if (!fifo_empty && fifo_head.in_query)
                    begin
                        total_reg   <= total_reg + TOTAL_W'(fifo_head.weight);
                        row_sum_reg <= row_sum_reg + ROWSUM_W'(fifo_head.weight);
                        if (fifo_head.in_window)
                        begin
                            window_reg <= window_reg + TOTAL_W'(fifo_head.weight);
                        end
                    end
                end
                BK_ACC:
                begin
                    row_x_reg <= row_x_reg + XLOG_W'(prod_reg);
                end
                BK_ROW_W:
                begin
                    if (div_done && (DIV_NUM_W'(lg_result) > div_quo))
                    begin
                        ent_sum_reg <= ent_sum_reg +
                                       ENTSUM_W'(lg_result - div_quo[LG_W-1:0]);
                    end
                end
                BK_ROW_CLR:
                begin
                    row_sum_reg <= '0;
                    row_x_reg   <= '0;
                end
                BK_EMIT:
                begin
                    if (emit_go)
                    begin
                        res_reg     <= emit_res;
                        total_reg   <= '0;
                        window_reg  <= '0;
                        ent_sum_reg <= '0;
                    end
                end
                default:
                begin
                    row_x_reg <= row_x_reg;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* src/attention_coherence_score_top.sv */
// ----------------------------------------------------------------------------
// attention_coherence_score_top
// Streams an attention matrix and reports window mass, entropy and score.
// ----------------------------------------------------------------------------
// Flow: the back end takes one queued weight at a time; a zero or non-query
//   weight passes straight through, a nonzero query weight waits for the
//   sixteen-step log2 squaring loop. Row end of a counted nonzero row waits
//   for log2 and the 64-step divider. Matrix end goes straight to the result
//   if flagged, else the mass, entropy, log2, optional focus and score steps.
// Reset: registers return to their reset values, counters, queue and
//   accumulators clear; no result is pending.
module attention_coherence_score_top
    import acs_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WEIGHT_W-1:0]  weight,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output logic [1:0]           status,
    output logic [MASS_W-1:0]    mass,
    output logic [ENT_W-1:0]     entropy,
    output logic                 consistent,
    output logic [MASS_W-1:0]    score,
    output logic [CFG_W-1:0]     token_total,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    beat_t   front_beat;
    beat_t   head_beat;
    logic    fifo_empty;
    logic    fifo_pop;
    logic    res_valid;
    result_t res;
    logic    accept;

    assign accept = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count     <= CFG_W'(1);
            cfg_reg.column_count  <= CFG_W'(1);
            cfg_reg.window_start  <= '0;
            cfg_reg.window_length <= '0;
            cfg_reg.query_first   <= '0;
            cfg_reg.query_count   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_COUNT:     cfg_reg.row_count     <= cfg_data;
                REG_COLUMN_COUNT:  cfg_reg.column_count  <= cfg_data;
                REG_WINDOW_START:  cfg_reg.window_start  <= cfg_data;
                REG_WINDOW_LENGTH: cfg_reg.window_length <= cfg_data;
                REG_QUERY_FIRST:   cfg_reg.query_first   <= cfg_data;
                REG_QUERY_COUNT:   cfg_reg.query_count   <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    acs_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .weight (weight),
        .beat   (front_beat)
    );

    acs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_beat),
        .full  (full),
        .pop   (fifo_pop),
        .dout  (head_beat),
        .empty (fifo_empty)
    );

    acs_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .fifo_head  (head_beat),
        .fifo_pop   (fifo_pop),
        .res_valid  (res_valid),
        .res_pop    (pop),
        .res        (res)
    );

    assign empty       = !res_valid;
    assign status      = res.status;
    assign mass        = res.mass;
    assign entropy     = res.entropy;
    assign consistent  = res.consistent;
    assign score       = res.score;
    assign token_total = res.token_total;

    // a flagged result carries no figures
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_OK) |->
        (mass == '0 && score == '0 && token_total == '0 && !consistent))
        else $error("flagged result carries nonzero fields");

    // consistency bit agrees with entropy
    a_cons: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STATUS_OK) |-> (consistent == (entropy < CONS_LIMIT)))
        else $error("consistent bit disagrees with entropy");

    // fractions stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (mass <= ONE_Q16 && score <= ONE_Q16))
        else $error("fraction above one");

endmodule
